/* rtl/amh_pkg.sv */
// Package for the Ali-Mikhail-Haq copula sampler: working-format constants,
// shared types and the truncating signed multiply. No dependencies.
`default_nettype none
package amh_pkg;
	localparam int WF = 28;
	localparam int WW = 36;
	typedef logic signed [WW-1:0] work_t;
	localparam work_t WONE = work_t'(64'sd1 <<< WF);

	function automatic work_t wmul(input work_t x, input work_t y);
		logic [WW-1:0] mx;
		logic [WW-1:0] my;
		logic [2*WW-1:0] p;
		logic [WW-1:0] r;
		begin
			mx = x[WW-1] ? WW'(-x) : WW'(x);
			my = y[WW-1] ? WW'(-y) : WW'(y);
			p = {{WW{1'b0}}, mx} * {{WW{1'b0}}, my};
			r = p[WF +: WW];
			wmul = (x[WW-1] ^ y[WW-1]) ? work_t'(-r) : work_t'(r);
		end
	endfunction
endpackage
`default_nettype wire

/* rtl/amh_isqrt.sv */
// Pipelined integer square root, one result bit per stage.
// Depends on nothing; carries a valid bit and a side payload.
`default_nettype none
module amh_isqrt #(
	parameter int IW = 64,
	parameter int SW = 80
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire logic [IW-1:0] radicand,
	input  wire logic [SW-1:0] side_in,
	output logic               out_valid,
	output logic [IW/2-1:0]    root,
	output logic [SW-1:0]      side_out
);
	localparam int N = IW / 2;
	logic [IW-1:0] rem_s [0:N];
	logic [N-1:0]  r_s   [0:N];
	logic [IW-1:0] x_s   [0:N];
	logic [SW-1:0] sd_s  [0:N];
	logic [N:0]    v_s;

	always_comb begin
		rem_s[0] = '0;
		r_s[0] = '0;
		x_s[0] = radicand;
		sd_s[0] = side_in;
		v_s[0] = in_valid;
	end

	for (genvar i = 0; i < N; i++) begin : g_st
		logic [IW-1:0] rem_n;
		logic [IW-1:0] trial;
		always_comb begin
			rem_n = {rem_s[i][IW-3:0], x_s[i][IW-1:IW-2]};
			trial = {{(IW-N-2){1'b0}}, r_s[i], 2'b01};
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else begin
				v_s[i+1] <= v_s[i];
			end
		end
		always_ff @(posedge clk) begin
			x_s[i+1] <= {x_s[i][IW-3:0], 2'b00};
			sd_s[i+1] <= sd_s[i];
			if (rem_n >= trial) begin
				rem_s[i+1] <= rem_n - trial;
				r_s[i+1] <= {r_s[i][N-2:0], 1'b1};
			end else begin
				rem_s[i+1] <= rem_n;
				r_s[i+1] <= {r_s[i][N-2:0], 1'b0};
			end
		end
	end

	assign out_valid = v_s[N];
	assign root = r_s[N];
	assign side_out = sd_s[N];
endmodule
`default_nettype wire

/* rtl/amh_divider.sv */
// Pipelined restoring divider for the final quotient, one bit per stage,
// with zero and saturation handling. Uses amh_pkg for the working type.
`default_nettype none
module amh_divider #(
	parameter int FRAC_BITS = 24
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire amh_pkg::work_t num,
	input  wire amh_pkg::work_t den,
	input  wire logic [23:0]   u_in,
	output logic               out_valid,
	output logic [23:0]        y,
	output logic [23:0]        u_out
);
	localparam int WW = amh_pkg::WW;
	localparam int N = FRAC_BITS;
	logic [WW:0]  rem_s [0:N];
	logic [WW-1:0] d_s  [0:N];
	logic [N-1:0] q_s   [0:N];
	logic [N:0]   v_s;
	logic [N:0]   z_s;
	logic [N:0]   sat_s;
	logic [23:0]  u_s   [0:N];

	always_comb begin
		v_s[0] = in_valid;
		z_s[0] = (num <= 0);
		sat_s[0] = (den <= 0) || (num >= den);
		rem_s[0] = {1'b0, WW'(num)};
		d_s[0] = WW'(den);
		q_s[0] = '0;
		u_s[0] = u_in;
	end

	for (genvar i = 0; i < N; i++) begin : g_st
		logic [WW:0] sh;
		always_comb sh = {rem_s[i][WW-1:0], 1'b0};
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else begin
				v_s[i+1] <= v_s[i];
			end
		end
		always_ff @(posedge clk) begin
			z_s[i+1] <= z_s[i];
			sat_s[i+1] <= sat_s[i];
			d_s[i+1] <= d_s[i];
			u_s[i+1] <= u_s[i];
			if (sh >= {1'b0, d_s[i]}) begin
				rem_s[i+1] <= sh - {1'b0, d_s[i]};
				q_s[i+1] <= {q_s[i][N-2:0], 1'b1};
			end else begin
				rem_s[i+1] <= sh;
				q_s[i+1] <= {q_s[i][N-2:0], 1'b0};
			end
		end
	end

	always_comb begin
		if (z_s[N]) begin
			y = '0;
		end else if (sat_s[N]) begin
			y = 24'((64'd1 << FRAC_BITS) - 64'd1);
		end else begin
			y = 24'(q_s[N]);
		end
	end
	assign out_valid = v_s[N];
	assign u_out = u_s[N];
endmodule
`default_nettype wire

/* rtl/amh_copula_sampler_unit.sv */
// Top level of the Ali-Mikhail-Haq copula sampler: polynomial pipeline,
// square-root and divider pipelines. Depends on amh_pkg, amh_isqrt, amh_divider.
//
//  channel   | handshake          | payload
//  input     | start / busy       | uniform_first, uniform_second
//  config    | cfg_valid/cfg_ready| cfg_data (theta, signed Q1.23)
//  result    | done strobe        | sample_first, sample_second
//
// One request enters per cycle; busy is always low. The path runs through
// polynomial stages 1 to 4, 32 square-root stages, stage 5 and FRAC_BITS
// divider stages, as the root and quotient pipelines give one bit per stage.
// Results leave on done for one cycle; the receiver cannot stall. Reset
// clears valid bits and sets theta to 0.5.
`default_nettype none
module amh_copula_sampler_unit #(
	parameter int FRAC_BITS = 24
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [23:0] uniform_first,
	input  wire logic [23:0] uniform_second,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic signed [23:0] cfg_data,
	output logic             done,
	output logic [23:0]      sample_first,
	output logic [23:0]      sample_second
);
	localparam int WF = amh_pkg::WF;
	localparam int WW = amh_pkg::WW;
	localparam amh_pkg::work_t ONE = amh_pkg::WONE;

	logic signed [23:0] theta_q;
	assign busy = 1'b0;
	assign cfg_ready = 1'b1;

	// hold theta
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			theta_q <= 24'sh400000;
		end else if (cfg_valid) begin
			theta_q <= cfg_data;
		end
	end

	// bring a Q0.FRAC_BITS fraction into the working format
	function automatic amh_pkg::work_t to_work(input logic [23:0] x);
		logic [23:0] m;
		begin
			m = 24'(x & 24'((64'd1 << FRAC_BITS) - 64'd1));
			if (FRAC_BITS >= WF) to_work = amh_pkg::work_t'({12'd0, m} >> (FRAC_BITS - WF));
			else to_work = amh_pkg::work_t'({12'd0, m} << (WF - FRAC_BITS));
		end
	endfunction

	// stage 1: operands, t^2, a*v, a*t, a*a
	logic v_s1;
	logic [23:0] u_s1;
	amh_pkg::work_t t_s1, vv_s1, a_s1, t2_s1, av_s1, at_s1, aa_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else v_s1 <= start;
	end
	always_ff @(posedge clk) begin
		automatic amh_pkg::work_t t, uu, vv, a;
		t = amh_pkg::work_t'(theta_q) <<< 5;
		uu = to_work(uniform_first);
		vv = to_work(uniform_second);
		a = ONE - uu;
		u_s1 <= 24'(uniform_first & 24'((64'd1 << FRAC_BITS) - 64'd1));
		t_s1 <= t;
		vv_s1 <= vv;
		a_s1 <= a;
		t2_s1 <= amh_pkg::wmul(t, t);
		av_s1 <= amh_pkg::wmul(a, vv);
		at_s1 <= amh_pkg::wmul(a, t);
		aa_s1 <= amh_pkg::wmul(a, a);
	end

	// stage 2: t*(2av+1), aa*v, delta, p^2
	logic v_s2;
	logic [23:0] u_s2;
	amh_pkg::work_t t_s2, t2_s2, a_s2, vv_s2, tb_s2, aav_s2, dl_s2, pp_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		automatic amh_pkg::work_t p;
		p = at_s1 - ONE;
		u_s2 <= u_s1;
		t_s2 <= t_s1;
		t2_s2 <= t2_s1;
		a_s2 <= a_s1;
		vv_s2 <= vv_s1;
		tb_s2 <= amh_pkg::wmul(t_s1, (av_s1 <<< 1) + ONE);
		aav_s2 <= amh_pkg::wmul(aa_s1, vv_s1);
		dl_s2 <= amh_pkg::wmul(vv_s1, a_s1 - ONE) <<< 2;
		pp_s2 <= amh_pkg::wmul(p, p);
	end

	// stage 3: b, a*delta, t*(delta+2), num
	logic v_s3;
	logic [23:0] u_s3;
	amh_pkg::work_t t2_s3, b_s3, ad_s3, td_s3, num_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else v_s3 <= v_s2;
	end
	always_ff @(posedge clk) begin
		u_s3 <= u_s2;
		t2_s3 <= t2_s2;
		b_s3 <= ONE - tb_s2 + (amh_pkg::wmul(t2_s2, aav_s2) <<< 1);
		ad_s3 <= amh_pkg::wmul(a_s2, dl_s2);
		td_s3 <= amh_pkg::wmul(t_s2, dl_s2 + (ONE <<< 1));
		num_s3 <= amh_pkg::wmul(vv_s2, pp_s2) <<< 1;
	end

	// stage 4: c, clamped at zero
	logic v_s4;
	logic [23:0] u_s4;
	amh_pkg::work_t b_s4, num_s4, c_s4;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else v_s4 <= v_s3;
	end
	always_ff @(posedge clk) begin
		automatic amh_pkg::work_t c;
		c = amh_pkg::wmul(t2_s3, ad_s3 + ONE) - td_s3 + ONE;
		u_s4 <= u_s3;
		b_s4 <= b_s3;
		num_s4 <= num_s3;
		c_s4 <= c[WW-1] ? '0 : c;
	end

	// square root of c * 2^WF
	localparam int SW = 2 * WW + 24;
	logic [63:0] rad;
	logic sq_v;
	logic [31:0] sq_root;
	logic [SW-1:0] sq_side;
	assign rad = 64'(c_s4) << WF;
	amh_isqrt #(.IW(64), .SW(SW)) u_sqrt (
		.clk(clk), .arst_n(arst_n), .in_valid(v_s4), .radicand(rad),
		.side_in({b_s4, num_s4, u_s4}),
		.out_valid(sq_v), .root(sq_root), .side_out(sq_side)
	);

	// stage 5: denominator
	logic v_s5;
	logic [23:0] u_s5;
	amh_pkg::work_t num_s5, den_s5;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else v_s5 <= sq_v;
	end
	always_ff @(posedge clk) begin
		u_s5 <= sq_side[23:0];
		num_s5 <= sq_side[24 +: WW];
		den_s5 <= amh_pkg::work_t'(sq_side[24+WW +: WW]) + amh_pkg::work_t'({4'd0, sq_root});
	end

	amh_divider #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk(clk), .arst_n(arst_n), .in_valid(v_s5), .num(num_s5), .den(den_s5),
		.u_in(u_s5), .out_valid(done), .y(sample_second), .u_out(sample_first)
	);
endmodule
`default_nettype wire
